// File: sv/rmsi_pkg.sv
`default_nettype none

package rmsi_pkg;

    localparam int NUM_PINS_DEF  = 5;
    localparam int AGE_WIDTH_DEF = 16;

    localparam int LINK_AGE_W = 17;
    localparam int PIN_IDX_W  = 3;
    localparam int WINDOW_W   = 10;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PIN_OUT_W  = 5;
    localparam int MOTION_W   = 5;
    localparam int NUM_LINES  = 5;
    localparam int MIN_VALUES = 3;
    localparam int LEFT_VALUES  = 4;
    localparam int RIGHT_VALUES = 5;

    // motion flag bit positions, also the line order for pin drive
    localparam int MOT_STOP  = 0;
    localparam int MOT_UP    = 1;
    localparam int MOT_DOWN  = 2;
    localparam int MOT_LEFT  = 3;
    localparam int MOT_RIGHT = 4;

    localparam logic [MOTION_W-1:0] STOP_ONLY = MOTION_W'(1);
    localparam logic [7:0]          ESTOP_CODE = 8'd1;

    localparam logic [PIN_IDX_W-1:0] ESTOP_PIN_RST = 3'd0;
    localparam logic [PIN_IDX_W-1:0] UP_PIN_RST    = 3'd1;
    localparam logic [PIN_IDX_W-1:0] DOWN_PIN_RST  = 3'd2;
    localparam logic [PIN_IDX_W-1:0] LEFT_PIN_RST  = 3'd3;
    localparam logic [PIN_IDX_W-1:0] RIGHT_PIN_RST = 3'd4;
    localparam logic [WINDOW_W-1:0]  WINDOW_RST    = 10'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 16'd30000;

    localparam logic [1:0] MISS_MAX = 2'd3;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_CONNECT    = 3'd1,
        KIND_DISCONNECT = 3'd2,
        KIND_LOGIN      = 3'd3,
        KIND_MOTION     = 3'd4,
        KIND_BEAT       = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        REPLY_NONE    = 3'd0,
        REPLY_REQUEST = 3'd1,
        REPLY_OK      = 3'd2,
        REPLY_FAIL    = 3'd3,
        REPLY_TIMEOUT = 3'd4
    } reply_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESTOP_PIN = 3'd0,
        CFG_UP_PIN    = 3'd1,
        CFG_DOWN_PIN  = 3'd2,
        CFG_LEFT_PIN  = 3'd3,
        CFG_RIGHT_PIN = 3'd4,
        CFG_WINDOW    = 3'd5,
        CFG_TIMEOUT   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       login_ok;
        logic [2:0] value_count;
        logic [7:0] estop_value;
        logic       up_req;
        logic       down_req;
        logic       left_req;
        logic       right_req;
        logic       beat_ok;
    } in_item_t;

    typedef struct packed {
        logic [PIN_OUT_W-1:0] pin_levels;
        logic [MOTION_W-1:0]  motion_status;
        logic                 status_notify;
        logic [1:0]           miss_level;
        logic [2:0]           login_reply;
        logic                 drop_link;
        logic                 logged_in;
    } out_item_t;

    typedef struct packed {
        logic [PIN_IDX_W-1:0] estop_pin;
        logic [PIN_IDX_W-1:0] up_pin;
        logic [PIN_IDX_W-1:0] down_pin;
        logic [PIN_IDX_W-1:0] left_pin;
        logic [PIN_IDX_W-1:0] right_pin;
        logic [WINDOW_W-1:0]  beat_window_ms;
        logic [TIMEOUT_W-1:0] login_timeout_ms;
    } cfg_t;

endpackage

`default_nettype wire

// File: sv/remote_motion_safety_interlock_unit.sv
// An item is held in the input register, and its result then waits in the result register.
// Throughput: one item per cycle while out_stall is low; the single state-update stage
// between the input register and the result register sets that figure.
// Reset (rst_n, asynchronous, active low): link and login down, stop only,
// pins low, miss level 3, registers back to their defaults, no item held.
`default_nettype none

module remote_motion_safety_interlock_unit #(
    parameter int NUM_PINS  = rmsi_pkg::NUM_PINS_DEF,
    parameter int AGE_WIDTH = rmsi_pkg::AGE_WIDTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire rmsi_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output rmsi_pkg::out_item_t                  out_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rmsi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rmsi_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                s1_valid_reg, s1_valid_next;
    rmsi_pkg::in_item_t  s1_item_reg, s1_item_next;
    logic                out_valid_reg, out_valid_next;
    rmsi_pkg::out_item_t out_item_reg, out_item_next;

    logic                advance;
    logic                in_take;
    rmsi_pkg::cfg_t      regs;
    rmsi_pkg::out_item_t step_result;

    rmsi_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    rmsi_step #(
        .NUM_PINS  (NUM_PINS),
        .AGE_WIDTH (AGE_WIDTH)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .regs    (regs),
        .result  (step_result)
    );

    // the held item moves on whenever the result register is free or draining
    assign advance   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !advance);
        s1_item_next   = in_take ? in_item : s1_item_reg;
        out_valid_next = advance || (out_valid_reg && out_stall);
        out_item_next  = advance ? step_result : out_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= s1_item_next;
        out_item_reg <= out_item_next;
    end

    a_stop_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.motion_status[rmsi_pkg::MOT_STOP]
        |-> out_item_reg.pin_levels == '0)
        else $error("pins driven while stop is set");

    a_drop_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.drop_link
        |-> out_item_reg.login_reply == rmsi_pkg::REPLY_FAIL ||
            out_item_reg.login_reply == rmsi_pkg::REPLY_TIMEOUT)
        else $error("link drop without fail or timeout reply");

    a_notify_login: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status_notify |-> out_item_reg.logged_in)
        else $error("status notify while not logged in");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && s1_valid_reg)
        else $error("input stalled with output free");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item lost from result register");

endmodule

`default_nettype wire

// File: sv/rmsi_cfg.sv
`default_nettype none

module rmsi_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rmsi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rmsi_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rmsi_pkg::cfg_t                           regs
);

    rmsi_pkg::cfg_t regs_reg;
    rmsi_pkg::cfg_t regs_next;

    assign cfg_ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (rmsi_pkg::cfg_idx_t'(cfg_index))
                rmsi_pkg::CFG_ESTOP_PIN:
                    regs_next.estop_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_UP_PIN:
                    regs_next.up_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_DOWN_PIN:
                    regs_next.down_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_LEFT_PIN:
                    regs_next.left_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_RIGHT_PIN:
                    regs_next.right_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_WINDOW:
                    regs_next.beat_window_ms = cfg_data[rmsi_pkg::WINDOW_W-1:0];
                rmsi_pkg::CFG_TIMEOUT:
                    regs_next.login_timeout_ms = cfg_data[rmsi_pkg::TIMEOUT_W-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.estop_pin        <= rmsi_pkg::ESTOP_PIN_RST;
            regs_reg.up_pin           <= rmsi_pkg::UP_PIN_RST;
            regs_reg.down_pin         <= rmsi_pkg::DOWN_PIN_RST;
            regs_reg.left_pin         <= rmsi_pkg::LEFT_PIN_RST;
            regs_reg.right_pin        <= rmsi_pkg::RIGHT_PIN_RST;
            regs_reg.beat_window_ms   <= rmsi_pkg::WINDOW_RST;
            regs_reg.login_timeout_ms <= rmsi_pkg::TIMEOUT_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/rmsi_step.sv
`default_nettype none

module rmsi_step #(
    parameter int NUM_PINS  = rmsi_pkg::NUM_PINS_DEF,
    parameter int AGE_WIDTH = rmsi_pkg::AGE_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire rmsi_pkg::in_item_t item,
    input  wire rmsi_pkg::cfg_t     regs,
    output rmsi_pkg::out_item_t     result
);

    // threshold compare width: 3 * window needs 12 bits
    localparam int CMP_W = (AGE_WIDTH > 12) ? AGE_WIDTH : 12;

    logic                              link_up_reg, link_up_next;
    logic                              login_done_reg, login_done_next;
    logic                              beat_seen_reg, beat_seen_next;
    logic [rmsi_pkg::MOTION_W-1:0]     flags_reg, flags_next;
    logic [AGE_WIDTH-1:0]              beat_age_reg, beat_age_next;
    logic [rmsi_pkg::LINK_AGE_W-1:0]   link_age_reg, link_age_next;
    logic [1:0]                        miss_reg, miss_next;
    logic [NUM_PINS-1:0]               pin_reg, pin_next;

    logic [AGE_WIDTH-1:0]              age_inc;
    logic [rmsi_pkg::LINK_AGE_W-1:0]   link_age_inc;
    logic [CMP_W-1:0]                  lim1, lim2, lim3;
    logic [CMP_W-1:0]                  age_inc_cmp, age_cur_cmp;
    logic                              inc_sat, cur_sat;
    logic                              exc1_inc, exc2_inc, exc3_inc, exc3_cur;

    logic                              pins_clear;
    logic                              do_refresh;
    logic                              healthy;
    logic                              notify;
    logic                              drop;
    rmsi_pkg::reply_t                  reply;
    logic                              up_v, dn_v, lf_v, rt_v;

    logic [rmsi_pkg::PIN_IDX_W-1:0]    line_idx [rmsi_pkg::NUM_LINES];
    logic                              line_lvl [rmsi_pkg::NUM_LINES];

    // saturating ages and heartbeat window compares
    always_comb
    begin
        inc_sat      = (beat_age_reg == {AGE_WIDTH{1'b1}});
        age_inc      = inc_sat ? beat_age_reg : beat_age_reg + AGE_WIDTH'(1);
        link_age_inc = (link_age_reg == {rmsi_pkg::LINK_AGE_W{1'b1}}) ? link_age_reg
                       : link_age_reg + rmsi_pkg::LINK_AGE_W'(1);
        lim1         = CMP_W'(regs.beat_window_ms);
        lim2         = CMP_W'({regs.beat_window_ms, 1'b0});
        lim3         = lim2 + lim1;
        age_inc_cmp  = CMP_W'(age_inc);
        age_cur_cmp  = CMP_W'(beat_age_reg);
        cur_sat      = inc_sat;
        // a saturated age counts as past every threshold
        exc1_inc     = (age_inc == {AGE_WIDTH{1'b1}}) || (age_inc_cmp > lim1);
        exc2_inc     = (age_inc == {AGE_WIDTH{1'b1}}) || (age_inc_cmp > lim2);
        exc3_inc     = (age_inc == {AGE_WIDTH{1'b1}}) || (age_inc_cmp > lim3);
        exc3_cur     = cur_sat || (age_cur_cmp > lim3);
    end

    always_comb
    begin
        link_up_next    = link_up_reg;
        login_done_next = login_done_reg;
        beat_seen_next  = beat_seen_reg;
        flags_next      = flags_reg;
        beat_age_next   = beat_age_reg;
        link_age_next   = link_age_reg;
        miss_next       = miss_reg;
        pins_clear      = 1'b0;
        do_refresh      = 1'b0;
        healthy         = 1'b0;
        notify          = 1'b0;
        drop            = 1'b0;
        reply           = rmsi_pkg::REPLY_NONE;
        up_v            = item.up_req & ~item.down_req;
        dn_v            = item.down_req & ~item.up_req;
        lf_v            = 1'b0;
        rt_v            = 1'b0;

        case (rmsi_pkg::kind_t'(item.kind))
            rmsi_pkg::KIND_TICK:
            begin
                beat_age_next = age_inc;
                link_age_next = link_age_inc;
                if (!link_up_reg)
                begin
                    flags_next = rmsi_pkg::STOP_ONLY;
                    pins_clear = 1'b1;
                end
                else if (!login_done_reg &&
                         link_age_inc > rmsi_pkg::LINK_AGE_W'(regs.login_timeout_ms))
                begin
                    reply = rmsi_pkg::REPLY_TIMEOUT;
                    drop  = 1'b1;
                end
                else
                begin
                    if (!beat_seen_reg || exc3_inc)
                        miss_next = rmsi_pkg::MISS_MAX;
                    else if (exc2_inc)
                        miss_next = 2'd2;
                    else if (exc1_inc)
                        miss_next = 2'd1;
                    else
                        miss_next = 2'd0;
                    healthy    = beat_seen_reg && !exc3_inc;
                    do_refresh = 1'b1;
                end
            end
            rmsi_pkg::KIND_CONNECT:
            begin
                link_up_next    = 1'b1;
                login_done_next = 1'b0;
                link_age_next   = '0;
                flags_next      = rmsi_pkg::STOP_ONLY;
                pins_clear      = 1'b1;
                reply           = rmsi_pkg::REPLY_REQUEST;
            end
            rmsi_pkg::KIND_DISCONNECT:
            begin
                link_up_next    = 1'b0;
                login_done_next = 1'b0;
                flags_next      = rmsi_pkg::STOP_ONLY;
                pins_clear      = 1'b1;
            end
            rmsi_pkg::KIND_LOGIN:
            begin
                if (item.login_ok)
                begin
                    login_done_next = 1'b1;
                    reply           = rmsi_pkg::REPLY_OK;
                end
                else
                begin
                    login_done_next = 1'b0;
                    reply           = rmsi_pkg::REPLY_FAIL;
                    drop            = 1'b1;
                end
            end
            rmsi_pkg::KIND_MOTION:
            begin
                if (login_done_reg && 32'(item.value_count) >= rmsi_pkg::MIN_VALUES)
                begin
                    if (32'(item.value_count) >= rmsi_pkg::LEFT_VALUES)
                        lf_v = item.left_req;
                    if (32'(item.value_count) >= rmsi_pkg::RIGHT_VALUES)
                        rt_v = item.right_req;
                    if (item.estop_value == rmsi_pkg::ESTOP_CODE)
                        flags_next = rmsi_pkg::STOP_ONLY;
                    else
                    begin
                        // opposing directions cancel each other
                        flags_next = '0;
                        flags_next[rmsi_pkg::MOT_UP]    = up_v;
                        flags_next[rmsi_pkg::MOT_DOWN]  = dn_v;
                        flags_next[rmsi_pkg::MOT_LEFT]  = lf_v & ~rt_v;
                        flags_next[rmsi_pkg::MOT_RIGHT] = rt_v & ~lf_v;
                    end
                    healthy    = beat_seen_reg && !exc3_cur;
                    do_refresh = 1'b1;
                    notify     = link_up_reg;
                end
            end
            rmsi_pkg::KIND_BEAT:
            begin
                if (login_done_reg && item.beat_ok)
                begin
                    beat_seen_next = 1'b1;
                    beat_age_next  = '0;
                    miss_next      = 2'd0;
                    healthy        = 1'b1;
                    do_refresh     = 1'b1;
                end
            end
            default:
            begin
                reply = rmsi_pkg::REPLY_NONE;
            end
        endcase
    end

    always_comb
    begin
        line_idx[rmsi_pkg::MOT_STOP]  = regs.estop_pin;
        line_idx[rmsi_pkg::MOT_UP]    = regs.up_pin;
        line_idx[rmsi_pkg::MOT_DOWN]  = regs.down_pin;
        line_idx[rmsi_pkg::MOT_LEFT]  = regs.left_pin;
        line_idx[rmsi_pkg::MOT_RIGHT] = regs.right_pin;
        line_lvl[rmsi_pkg::MOT_STOP]  = 1'b1;
        line_lvl[rmsi_pkg::MOT_UP]    = flags_next[rmsi_pkg::MOT_UP];
        line_lvl[rmsi_pkg::MOT_DOWN]  = flags_next[rmsi_pkg::MOT_DOWN];
        line_lvl[rmsi_pkg::MOT_LEFT]  = flags_next[rmsi_pkg::MOT_LEFT];
        line_lvl[rmsi_pkg::MOT_RIGHT] = flags_next[rmsi_pkg::MOT_RIGHT];
    end

    // pin refresh: later lines override earlier ones on a shared pin;
    // unassigned indexes match no pin and the pin keeps its level
    always_comb
    begin
        pin_next = pin_reg;
        if (pins_clear)
            pin_next = '0;
        else if (do_refresh)
        begin
            if (!link_up_next || !login_done_next || !healthy ||
                flags_next[rmsi_pkg::MOT_STOP])
                pin_next = '0;
            else
            begin
                for (int p = 0; p < NUM_PINS; p++)
                begin
                    for (int l = 0; l < rmsi_pkg::NUM_LINES; l++)
                    begin
                        if (int'(line_idx[l]) == p)
                            pin_next[p] = line_lvl[l];
                    end
                end
            end
        end
    end

    always_comb
    begin
        result.pin_levels    = rmsi_pkg::PIN_OUT_W'(pin_next);
        result.motion_status = flags_next;
        result.status_notify = notify;
        result.miss_level    = miss_next;
        result.login_reply   = reply;
        result.drop_link     = drop;
        result.logged_in     = login_done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg    <= 1'b0;
            login_done_reg <= 1'b0;
            beat_seen_reg  <= 1'b0;
            flags_reg      <= rmsi_pkg::STOP_ONLY;
            beat_age_reg   <= '0;
            link_age_reg   <= '0;
            miss_reg       <= rmsi_pkg::MISS_MAX;
            pin_reg        <= '0;
        end
        else if (advance)
        begin
            link_up_reg    <= link_up_next;
            login_done_reg <= login_done_next;
            beat_seen_reg  <= beat_seen_next;
            flags_reg      <= flags_next;
            beat_age_reg   <= beat_age_next;
            link_age_reg   <= link_age_next;
            miss_reg       <= miss_next;
            pin_reg        <= pin_next;
        end
    end

endmodule

`default_nettype wire

// File: bench/remote_motion_safety_interlock_unit_test.sv
`timescale 1ns / 100ps

module remote_motion_safety_interlock_unit_test;

    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;
    localparam logic [rmsi_pkg::PIN_IDX_W-1:0] PIN_UNASSIGNED = 3'd5;
    localparam logic [rmsi_pkg::PIN_IDX_W-1:0] PIN_NONE_TOP   = 3'd7;
    localparam logic [rmsi_pkg::AGE_WIDTH_DEF-1:0] BEAT_AGE_MAX = '1;
    localparam logic [rmsi_pkg::LINK_AGE_W-1:0]    LINK_AGE_MAX = '1;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 180;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct {
        rmsi_pkg::in_item_t  ev;
        bit                  known;
        rmsi_pkg::out_item_t want;
    } script_row_t;

    typedef struct {
        bit                  known;
        rmsi_pkg::out_item_t value;
    } typed_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    rmsi_pkg::in_item_t              in_item;
    logic                            out_valid;
    logic                            out_stall;
    rmsi_pkg::out_item_t             out_item;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rmsi_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rmsi_pkg::CFG_DATA_W-1:0] cfg_data;

    // interlock state as predicted
    logic                                link_is_up     = 1'b0;
    logic                                user_logged_in = 1'b0;
    logic                                beat_ever_seen = 1'b0;
    logic [rmsi_pkg::MOTION_W-1:0]       motion_now     = rmsi_pkg::STOP_ONLY;
    logic [rmsi_pkg::AGE_WIDTH_DEF-1:0]  beat_age_now   = '0;
    logic [rmsi_pkg::LINK_AGE_W-1:0]     link_age_now   = '0;
    logic [1:0]                          miss_now       = rmsi_pkg::MISS_MAX;
    logic [rmsi_pkg::PIN_OUT_W-1:0]      pins_now       = '0;
    rmsi_pkg::cfg_t settings = '{rmsi_pkg::ESTOP_PIN_RST, rmsi_pkg::UP_PIN_RST,
                                 rmsi_pkg::DOWN_PIN_RST, rmsi_pkg::LEFT_PIN_RST,
                                 rmsi_pkg::RIGHT_PIN_RST, rmsi_pkg::WINDOW_RST,
                                 rmsi_pkg::TIMEOUT_RST};

    typed_result_t       typed_results[$];
    rmsi_pkg::out_item_t expected_results[$];
    int                  mismatches = 0;
    int                  cycle_count = 0;
    bit                  sender_idles = 1'b1;
    bit                  receiver_stalls = 1'b1;
    bit                  hold_long = 1'b0;

    remote_motion_safety_interlock_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit beat_late(input int unsigned limit);
        return beat_age_now == BEAT_AGE_MAX || 32'(beat_age_now) > limit;
    endfunction

    function automatic void drive_line(inout logic [rmsi_pkg::PIN_OUT_W-1:0] v,
                                       input logic [rmsi_pkg::PIN_IDX_W-1:0] idx,
                                       input logic level);
        if (32'(idx) < rmsi_pkg::NUM_PINS_DEF)
            v[idx] = level;
    endfunction

    function automatic void refresh_pin_drive();
        logic [rmsi_pkg::PIN_OUT_W-1:0] v;
        logic                           healthy;
        healthy = beat_ever_seen && !beat_late(3 * 32'(settings.beat_window_ms));
        if (!link_is_up || !user_logged_in || !healthy || motion_now[rmsi_pkg::MOT_STOP])
        begin
            pins_now = '0;
        end
        else
        begin
            v = pins_now;
            // later lines win a shared pin
            drive_line(v, settings.estop_pin, 1'b1);
            drive_line(v, settings.up_pin, motion_now[rmsi_pkg::MOT_UP]);
            drive_line(v, settings.down_pin, motion_now[rmsi_pkg::MOT_DOWN]);
            drive_line(v, settings.left_pin, motion_now[rmsi_pkg::MOT_LEFT]);
            drive_line(v, settings.right_pin, motion_now[rmsi_pkg::MOT_RIGHT]);
            pins_now = v;
        end
    endfunction

    task automatic predict_interlock(input rmsi_pkg::in_item_t ev,
                                     output rmsi_pkg::out_item_t r);
        logic             notify;
        logic             drop;
        logic             up;
        logic             dn;
        logic             lf;
        logic             rt;
        rmsi_pkg::reply_t reply;
        int unsigned      w;
        notify = 1'b0;
        drop   = 1'b0;
        reply  = rmsi_pkg::REPLY_NONE;
        w      = 32'(settings.beat_window_ms);
        case (ev.kind)
            rmsi_pkg::KIND_TICK:
            begin
                if (beat_age_now != BEAT_AGE_MAX)
                    beat_age_now++;
                if (link_age_now != LINK_AGE_MAX)
                    link_age_now++;
                if (!link_is_up)
                begin
                    motion_now = rmsi_pkg::STOP_ONLY;
                    pins_now   = '0;
                end
                else if (!user_logged_in &&
                         link_age_now > rmsi_pkg::LINK_AGE_W'(settings.login_timeout_ms))
                begin
                    reply = rmsi_pkg::REPLY_TIMEOUT;
                    drop  = 1'b1;
                end
                else
                begin
                    if (!beat_ever_seen || beat_late(3 * w))
                        miss_now = rmsi_pkg::MISS_MAX;
                    else if (beat_late(2 * w))
                        miss_now = 2'd2;
                    else if (beat_late(w))
                        miss_now = 2'd1;
                    else
                        miss_now = 2'd0;
                    refresh_pin_drive();
                end
            end
            rmsi_pkg::KIND_CONNECT:
            begin
                link_is_up     = 1'b1;
                user_logged_in = 1'b0;
                link_age_now   = '0;
                motion_now     = rmsi_pkg::STOP_ONLY;
                pins_now       = '0;
                reply          = rmsi_pkg::REPLY_REQUEST;
            end
            rmsi_pkg::KIND_DISCONNECT:
            begin
                link_is_up     = 1'b0;
                user_logged_in = 1'b0;
                motion_now     = rmsi_pkg::STOP_ONLY;
                pins_now       = '0;
            end
            rmsi_pkg::KIND_LOGIN:
            begin
                if (ev.login_ok)
                begin
                    user_logged_in = 1'b1;
                    reply          = rmsi_pkg::REPLY_OK;
                end
                else
                begin
                    user_logged_in = 1'b0;
                    reply          = rmsi_pkg::REPLY_FAIL;
                    drop           = 1'b1;
                end
            end
            rmsi_pkg::KIND_MOTION:
            begin
                if (user_logged_in && 32'(ev.value_count) >= rmsi_pkg::MIN_VALUES)
                begin
                    up = ev.up_req;
                    dn = ev.down_req;
                    lf = (32'(ev.value_count) >= rmsi_pkg::LEFT_VALUES) ?
                         ev.left_req : 1'b0;
                    rt = (32'(ev.value_count) >= rmsi_pkg::RIGHT_VALUES) ?
                         ev.right_req : 1'b0;
                    if (up && dn)
                    begin
                        up = 1'b0;
                        dn = 1'b0;
                    end
                    if (lf && rt)
                    begin
                        lf = 1'b0;
                        rt = 1'b0;
                    end
                    if (ev.estop_value == rmsi_pkg::ESTOP_CODE)
                        motion_now = rmsi_pkg::STOP_ONLY;
                    else
                        motion_now = {rt, lf, dn, up, 1'b0};
                    refresh_pin_drive();
                    notify = link_is_up;
                end
            end
            rmsi_pkg::KIND_BEAT:
            begin
                if (user_logged_in && ev.beat_ok)
                begin
                    beat_ever_seen = 1'b1;
                    beat_age_now   = '0;
                    miss_now       = 2'd0;
                    refresh_pin_drive();
                end
            end
            default: ;
        endcase
        r.pin_levels    = pins_now;
        r.motion_status = motion_now;
        r.status_notify = notify;
        r.miss_level    = miss_now;
        r.login_reply   = reply;
        r.drop_link     = drop;
        r.logged_in     = user_logged_in;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result(input rmsi_pkg::out_item_t want,
                                  input rmsi_pkg::out_item_t got);
        check_field("pin_levels", 8'(want.pin_levels), 8'(got.pin_levels));
        check_field("motion_status", 8'(want.motion_status), 8'(got.motion_status));
        check_field("status_notify", 8'(want.status_notify), 8'(got.status_notify));
        check_field("miss_level", 8'(want.miss_level), 8'(got.miss_level));
        check_field("login_reply", 8'(want.login_reply), 8'(got.login_reply));
        check_field("drop_link", 8'(want.drop_link), 8'(got.drop_link));
        check_field("logged_in", 8'(want.logged_in), 8'(got.logged_in));
    endtask

    // one process for both sides keeps push and pop order fixed within an edge
    always @(posedge clk)
    begin : scoreboard
        rmsi_pkg::out_item_t predicted;
        typed_result_t       plan;
        if (out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected, got %h", $time, out_item);
                mismatches++;
            end
            else
            begin
                compare_result(expected_results.pop_front(), out_item);
            end
        end
        if (in_valid && !in_stall)
        begin
            predict_interlock(in_item, predicted);
            plan = typed_results.pop_front();
            expected_results.push_back(plan.known ? plan.value : predicted);
        end
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rmsi_pkg::CFG_ESTOP_PIN:
                    settings.estop_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_UP_PIN:
                    settings.up_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_DOWN_PIN:
                    settings.down_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_LEFT_PIN:
                    settings.left_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_RIGHT_PIN:
                    settings.right_pin = cfg_data[rmsi_pkg::PIN_IDX_W-1:0];
                rmsi_pkg::CFG_WINDOW:
                    settings.beat_window_ms = cfg_data[rmsi_pkg::WINDOW_W-1:0];
                rmsi_pkg::CFG_TIMEOUT:
                    settings.login_timeout_ms = cfg_data[rmsi_pkg::TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : result_sink
        int pause;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            pause = receiver_stalls ? $urandom_range(0, 3) : 0;
            if (hold_long)
            begin
                pause     = HOLD_CYCLES;
                hold_long = 1'b0;
            end
            if (pause > 0)
            begin
                out_stall <= 1'b1;
                repeat (pause) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic rmsi_pkg::in_item_t event_of(input logic [2:0] kind, input logic ok,
                                                    input logic [2:0] cnt,
                                                    input logic [7:0] estop,
                                                    input logic up, input logic dn,
                                                    input logic lf, input logic rt,
                                                    input logic beat);
        rmsi_pkg::in_item_t ev;
        ev = '{kind, ok, cnt, estop, up, dn, lf, rt, beat};
        return ev;
    endfunction

    function automatic rmsi_pkg::out_item_t result_of(
        input logic [rmsi_pkg::PIN_OUT_W-1:0] pins,
        input logic [rmsi_pkg::MOTION_W-1:0]  motion,
        input logic notify, input logic [1:0] miss,
        input rmsi_pkg::reply_t reply, input logic drop,
        input logic logged);
        rmsi_pkg::out_item_t r;
        r = '{pins, motion, notify, miss, reply, drop, logged};
        return r;
    endfunction

    function automatic rmsi_pkg::in_item_t random_event();
        rmsi_pkg::in_item_t ev;
        int                 roll;
        ev.kind        = rmsi_pkg::KIND_TICK;
        ev.login_ok    = 1'($urandom_range(0, 1));
        ev.value_count = 3'($urandom_range(0, 7));
        ev.estop_value = 8'($urandom_range(0, 255));
        ev.up_req      = 1'($urandom_range(0, 1));
        ev.down_req    = 1'($urandom_range(0, 1));
        ev.left_req    = 1'($urandom_range(0, 1));
        ev.right_req   = 1'($urandom_range(0, 1));
        ev.beat_ok     = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 40)
            ev.kind = rmsi_pkg::KIND_TICK;
        else if (roll < 62)
        begin
            ev.kind = rmsi_pkg::KIND_MOTION;
            if ($urandom_range(0, 4) != 0)
                ev.value_count = 3'($urandom_range(rmsi_pkg::MIN_VALUES,
                                                   rmsi_pkg::RIGHT_VALUES));
            roll = $urandom_range(0, 9);
            if (roll < 2)
                ev.estop_value = rmsi_pkg::ESTOP_CODE;
            else if (roll < 7)
                ev.estop_value = 8'd0;
        end
        else if (roll < 77)
        begin
            ev.kind    = rmsi_pkg::KIND_BEAT;
            ev.beat_ok = ($urandom_range(0, 9) != 0);
        end
        else if (roll < 83)
        begin
            ev.kind     = rmsi_pkg::KIND_LOGIN;
            ev.login_ok = ($urandom_range(0, 99) < 85);
        end
        else if (roll < 88)
            ev.kind = rmsi_pkg::KIND_CONNECT;
        else if (roll < 92)
            ev.kind = rmsi_pkg::KIND_DISCONNECT;
        else if (roll < 95)
            ev.kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
        else
            ev.kind = 3'($urandom_range(0, 7));
        return ev;
    endfunction

    function automatic rmsi_pkg::cfg_t choose_settings(input int phase);
        rmsi_pkg::cfg_t s;
        case (phase)
            0:
            begin
                s = '{rmsi_pkg::ESTOP_PIN_RST, rmsi_pkg::UP_PIN_RST,
                      rmsi_pkg::DOWN_PIN_RST, rmsi_pkg::LEFT_PIN_RST,
                      rmsi_pkg::RIGHT_PIN_RST, 10'd1, 16'd1};
            end
            1:
            begin
                // down and left share pin 0, left wins
                s = '{PIN_UNASSIGNED, PIN_NONE_TOP, 3'd0, 3'd0, 3'd4,
                      10'd1000, 16'd65535};
            end
            default:
            begin
                s.estop_pin        = 3'($urandom_range(0, 7));
                s.up_pin           = 3'($urandom_range(0, 7));
                s.down_pin         = 3'($urandom_range(0, 7));
                s.left_pin         = 3'($urandom_range(0, 7));
                s.right_pin        = 3'($urandom_range(0, 7));
                s.beat_window_ms   = 10'($urandom_range(1, 6));
                s.login_timeout_ms = 16'($urandom_range(1, 40));
            end
        endcase
        return s;
    endfunction

    task automatic put_reg(input rmsi_pkg::cfg_idx_t idx,
                           input logic [rmsi_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic load_settings(input rmsi_pkg::cfg_t s);
        put_reg(rmsi_pkg::CFG_ESTOP_PIN, rmsi_pkg::CFG_DATA_W'(s.estop_pin));
        put_reg(rmsi_pkg::CFG_UP_PIN, rmsi_pkg::CFG_DATA_W'(s.up_pin));
        put_reg(rmsi_pkg::CFG_DOWN_PIN, rmsi_pkg::CFG_DATA_W'(s.down_pin));
        put_reg(rmsi_pkg::CFG_LEFT_PIN, rmsi_pkg::CFG_DATA_W'(s.left_pin));
        put_reg(rmsi_pkg::CFG_RIGHT_PIN, rmsi_pkg::CFG_DATA_W'(s.right_pin));
        put_reg(rmsi_pkg::CFG_WINDOW, rmsi_pkg::CFG_DATA_W'(s.beat_window_ms));
        put_reg(rmsi_pkg::CFG_TIMEOUT, s.login_timeout_ms);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_event(input rmsi_pkg::in_item_t ev, input bit known,
                               input rmsi_pkg::out_item_t want);
        int gap;
        gap = sender_idles ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        typed_results.push_back('{known, want});
        in_valid <= 1'b1;
        in_item  <= ev;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        do @(posedge clk);
        while (typed_results.size() != 0 || expected_results.size() != 0);
    endtask

    initial
    begin
        script_row_t         script[$];
        rmsi_pkg::in_item_t  ev;
        rmsi_pkg::out_item_t idle_reset;
        int                  phase;
        int                  n;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_reset = result_of('0, rmsi_pkg::STOP_ONLY, 1'b0, rmsi_pkg::MISS_MAX,
                               rmsi_pkg::REPLY_NONE, 1'b0, 1'b0);
        script.push_back('{event_of(rmsi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           idle_reset});
        script.push_back('{event_of(KIND_SPARE6, 1, 7, 8'hFF, 1, 1, 1, 1, 1), 1'b1,
                           idle_reset});
        // login is taken even with the link down
        script.push_back('{event_of(rmsi_pkg::KIND_LOGIN, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           result_of('0, rmsi_pkg::STOP_ONLY, 0, rmsi_pkg::MISS_MAX,
                                     rmsi_pkg::REPLY_OK, 0, 1)});
        script.push_back('{event_of(rmsi_pkg::KIND_CONNECT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           result_of('0, rmsi_pkg::STOP_ONLY, 0, rmsi_pkg::MISS_MAX,
                                     rmsi_pkg::REPLY_REQUEST, 0, 0)});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 5, 0, 1, 0, 0, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_LOGIN, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                           result_of('0, rmsi_pkg::STOP_ONLY, 0, rmsi_pkg::MISS_MAX,
                                     rmsi_pkg::REPLY_FAIL, 1, 0)});
        script.push_back('{event_of(rmsi_pkg::KIND_LOGIN, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 2, 0, 1, 0, 0, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_BEAT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_BEAT, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 5, 0, 1, 0, 1, 0, 0), 1'b0,
                           '0});
        // up with down cancels; left ignored with three values
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 3, 0, 1, 1, 1, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 4, 2, 1, 0, 1, 1, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 7, 8'hFF, 0, 1, 0, 1, 0),
                           1'b0, '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 5, rmsi_pkg::ESTOP_CODE,
                                    1, 0, 0, 0, 0), 1'b0, '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 5, 0, 0, 1, 0, 1, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(KIND_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        script.push_back('{event_of(rmsi_pkg::KIND_BEAT, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_DISCONNECT, 0, 0, 0, 0, 0, 0, 0, 0),
                           1'b0, '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 5, 0, 1, 0, 0, 0, 0), 1'b0,
                           '0});
        // logged in with link down: command stored, no notify
        script.push_back('{event_of(rmsi_pkg::KIND_LOGIN, 1, 0, 0, 0, 0, 0, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_MOTION, 0, 5, 0, 1, 0, 0, 0, 0), 1'b0,
                           '0});
        script.push_back('{event_of(rmsi_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0,
                           '0});
        foreach (script[i])
            offer_event(script[i].ev, script[i].known, script[i].want);

        for (phase = 0; phase < PHASES; phase++)
        begin
            pause_until_drained();
            load_settings(choose_settings(phase));
            sender_idles    = (phase != 2 && phase != 3);
            receiver_stalls = (phase != 3);
            if (phase == 2)
                hold_long = 1'b1;
            // open a session so that the rest reaches the driving states
            ev = random_event();
            ev.kind = rmsi_pkg::KIND_CONNECT;
            offer_event(ev, 1'b0, '0);
            ev = random_event();
            ev.kind = rmsi_pkg::KIND_LOGIN;
            ev.login_ok = 1'b1;
            offer_event(ev, 1'b0, '0);
            ev = random_event();
            ev.kind = rmsi_pkg::KIND_BEAT;
            ev.beat_ok = 1'b1;
            offer_event(ev, 1'b0, '0);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    pause_until_drained();
                offer_event(random_event(), 1'b0, '0);
            end
        end

        pause_until_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
sv/rmsi_pkg.sv
sv/rmsi_cfg.sv
sv/rmsi_step.sv
sv/remote_motion_safety_interlock_unit.sv
bench/remote_motion_safety_interlock_unit_test.sv
